// ===== hdl/utf8_stream_decoder_top_defines.svh =====
// Assertion macros of the UTF-8 stream decoder, used by the decode module.
`ifndef UTF8_STREAM_DECODER_TOP_DEFINES_SVH
`define UTF8_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define U8SD_ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("u8sd assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define U8SD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("u8sd assertion failed");

`endif

// ===== hdl/u8sd_pkg.sv =====
// Types, constants and the lead byte decoder of the UTF-8 stream decoder.
`timescale 1ns / 1ps

package u8sd_pkg;

  localparam int unsigned CpWidth    = 31;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned CountWidth = 3;
  localparam int unsigned ContBits   = 6;

  localparam logic [7:0] ContMask = 8'h3F;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_LEAD  = 2'd1,
    ERR_TRUNC = 2'd2
  } err_kind_e;

  typedef struct packed {
    logic [ByteWidth-1:0] data_byte;
    logic                 last_byte;
  } in_item_t;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic [1:0]         error_kind;
  } out_item_t;

  typedef struct packed {
    logic                  ascii;
    logic                  lead_ok;
    logic [CountWidth-1:0] count;
    logic [4:0]            bits;
  } lead_t;

  function automatic lead_t decode_lead(input logic [7:0] b);
    lead_t r;
    r = '0;
    if ((b & 8'h80) == 8'h00) begin
      r.ascii = 1'b1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      r.lead_ok = 1'b1;
      r.count   = 3'd1;
      r.bits    = b[4:0];
    end else if ((b & 8'hF0) == 8'hE0) begin
      r.lead_ok = 1'b1;
      r.count   = 3'd2;
      r.bits    = {1'b0, b[3:0]};
    end else if ((b & 8'hF8) == 8'hF0) begin
      r.lead_ok = 1'b1;
      r.count   = 3'd3;
      r.bits    = {2'b00, b[2:0]};
    end else if ((b & 8'hFC) == 8'hF8) begin
      r.lead_ok = 1'b1;
      r.count   = 3'd4;
      r.bits    = {3'b000, b[1:0]};
    end else if ((b & 8'hFE) == 8'hFC) begin
      r.lead_ok = 1'b1;
      r.count   = 3'd5;
      r.bits    = {4'b0000, b[0]};
    end
    return r;
  endfunction

endpackage

// ===== hdl/u8sd_in_stage.sv =====
// Input register stage of the UTF-8 stream decoder.
`timescale 1ns / 1ps

module u8sd_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  u8sd_pkg::in_item_t  in_data_i,
  output logic                item_valid_o,
  input  logic                item_take_i,
  output u8sd_pkg::in_item_t  item_o
);

  logic               valid_q;
  u8sd_pkg::in_item_t data_q;

  assign in_ready_o   = !valid_q || item_take_i;
  assign item_valid_o = valid_q;
  assign item_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

endmodule

// ===== hdl/u8sd_decode.sv =====
// Decode step of the UTF-8 stream decoder: sequence state and accumulator update.
`timescale 1ns / 1ps

`include "utf8_stream_decoder_top_defines.svh"

module u8sd_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  output logic                item_take_o,
  input  u8sd_pkg::in_item_t  item_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output u8sd_pkg::out_item_t res_o
);

  logic [u8sd_pkg::CountWidth-1:0] bytes_left_q, bytes_left_d;
  logic [u8sd_pkg::CpWidth-1:0]    partial_q, partial_d;
  logic [u8sd_pkg::CountWidth-1:0] left_dec;
  logic [u8sd_pkg::CpWidth-1:0]    acc;
  u8sd_pkg::lead_t                 lead;
  logic                            emit;

  assign lead     = u8sd_pkg::decode_lead(item_i.data_byte);
  assign left_dec = bytes_left_q - 3'd1;
  assign acc      = {partial_q[u8sd_pkg::CpWidth-u8sd_pkg::ContBits-1:0],
                     item_i.data_byte[u8sd_pkg::ContBits-1:0]};

  always_comb begin
    bytes_left_d     = bytes_left_q;
    partial_d        = partial_q;
    emit             = 1'b0;
    res_o.code_point = '0;
    res_o.error_kind = u8sd_pkg::ERR_NONE;
    if (bytes_left_q == '0) begin
      if (lead.ascii) begin
        emit             = 1'b1;
        res_o.code_point = {23'd0, item_i.data_byte};
      end else if (!lead.lead_ok) begin
        emit             = 1'b1;
        res_o.error_kind = u8sd_pkg::ERR_LEAD;
      end else if (item_i.last_byte) begin
        emit             = 1'b1;
        res_o.error_kind = u8sd_pkg::ERR_TRUNC;
        partial_d        = '0;
      end else begin
        bytes_left_d = lead.count;
        partial_d    = {26'd0, lead.bits};
      end
    end else begin
      bytes_left_d = left_dec;
      partial_d    = acc;
      if (left_dec == '0) begin
        emit             = 1'b1;
        res_o.code_point = acc;
        partial_d        = '0;
      end else if (item_i.last_byte) begin
        emit             = 1'b1;
        res_o.error_kind = u8sd_pkg::ERR_TRUNC;
        bytes_left_d     = '0;
        partial_d        = '0;
      end
    end
  end

  assign res_valid_o = item_valid_i && emit;
  assign item_take_o = item_valid_i && (!emit || res_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      partial_q    <= '0;
    end else if (item_take_o) begin
      bytes_left_q <= bytes_left_d;
      partial_q    <= partial_d;
    end
  end

  `U8SD_ASSERT_SAME(a_error_zero_cp, clk_i, rst_ni,
    res_valid_o && (res_o.error_kind != u8sd_pkg::ERR_NONE), res_o.code_point == '0)
  `U8SD_ASSERT_SAME(a_count_bounded, clk_i, rst_ni, 1'b1, bytes_left_q <= 3'd5)
  `U8SD_ASSERT_NEXT(a_last_ends_seq, clk_i, rst_ni,
    item_take_o && item_i.last_byte, bytes_left_q == '0)
  `U8SD_ASSERT_NEXT(a_cont_counts_down, clk_i, rst_ni,
    item_take_o && (bytes_left_q != '0) && !item_i.last_byte,
    bytes_left_q == ($past(bytes_left_q) - 3'd1))

endmodule

// ===== hdl/u8sd_out_stage.sv =====
// Result register stage of the UTF-8 stream decoder.
`timescale 1ns / 1ps

module u8sd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  output logic                res_ready_o,
  input  u8sd_pkg::out_item_t res_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output u8sd_pkg::out_item_t out_data_o
);

  logic                valid_q;
  u8sd_pkg::out_item_t data_q;

  assign res_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_i;
    end
  end

endmodule

// ===== hdl/utf8_stream_decoder_top.sv =====
// Top level of the UTF-8 stream decoder.
`timescale 1ns / 1ps

// Decodes UTF-8 text, including the legacy five- and six-byte forms, one byte per
// transfer and returns one code point transfer when a sequence completes. An invalid
// lead byte gives a result with error kind 1, and a sequence cut short by the last
// byte flag gives error kind 2; both carry a zero code point. A byte passes through
// an input register and then a single decode step that shifts six bits into the
// accumulator before reaching the result register. A result is written to the
// result register when the decode step takes its final byte from the input register,
// and one byte is accepted in every cycle while the output side keeps up. Continuation
// bytes and overlong forms are not checked.

module utf8_stream_decoder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  u8sd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output u8sd_pkg::out_item_t out_data_o
);

  logic                item_valid;
  logic                item_take;
  u8sd_pkg::in_item_t  item;
  logic                res_valid;
  logic                res_ready;
  u8sd_pkg::out_item_t res;

  u8sd_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .item_valid_o(item_valid),
    .item_take_i (item_take),
    .item_o      (item)
  );

  u8sd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_take_o (item_take),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  u8sd_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_ready_o(res_ready),
    .res_i      (res),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
